// ----- rtl/crp_pkg.sv -----
`default_nettype none

package crp_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR     = 2'd0,
		CMD_APPEND    = 2'd1,
		CMD_ADVANCE   = 2'd2,
		CMD_RESET_POS = 2'd3
	} cmd_t;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_SHORT = 2'd2;

	localparam int NUM_LANES = 6;
	localparam logic [2:0] MAC_LAST = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WRAP,
		ST_DIV,
		ST_IDX,
		ST_T3,
		ST_WGT,
		ST_MAC,
		ST_ROUND,
		ST_DONE
	} fsm_state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_EXEC,
		OP_WRAP,
		OP_DIV,
		OP_IDX,
		OP_T3,
		OP_WGT,
		OP_MAC,
		OP_ROUND,
		OP_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] cnt;
	} dp_ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic few;
		logic div_done;
	} dp_stat_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] eye_in_x;
		logic [31:0] eye_in_y;
		logic [31:0] eye_in_z;
		logic [31:0] look_in_x;
		logic [31:0] look_in_y;
		logic [31:0] look_in_z;
		logic [17:0] time_delta;
	} req_payload_t;

	typedef struct packed {
		logic [31:0] eye_x;
		logic [31:0] eye_y;
		logic [31:0] eye_z;
		logic [31:0] look_x;
		logic [31:0] look_y;
		logic [31:0] look_z;
		logic [1:0]  status;
		logic [5:0]  segment_index;
		logic [6:0]  points_held;
	} rsp_payload_t;

endpackage

`default_nettype wire

// ----- rtl/crp_ifs.sv -----
`default_nettype none

interface crp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic signed [31:0] eye_in_x;
	logic signed [31:0] eye_in_y;
	logic signed [31:0] eye_in_z;
	logic signed [31:0] look_in_x;
	logic signed [31:0] look_in_y;
	logic signed [31:0] look_in_z;
	logic [17:0] time_delta;

	modport source (output valid, command, eye_in_x, eye_in_y, eye_in_z,
		look_in_x, look_in_y, look_in_z, time_delta, input ready);
	modport sink (input valid, command, eye_in_x, eye_in_y, eye_in_z,
		look_in_x, look_in_y, look_in_z, time_delta, output ready);
endinterface

interface crp_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] eye_x;
	logic signed [31:0] eye_y;
	logic signed [31:0] eye_z;
	logic signed [31:0] look_x;
	logic signed [31:0] look_y;
	logic signed [31:0] look_z;
	logic [1:0]  status;
	logic [5:0]  segment_index;
	logic [6:0]  points_held;

	modport source (output valid, eye_x, eye_y, eye_z, look_x, look_y, look_z,
		status, segment_index, points_held, input ready);
	modport sink (input valid, eye_x, eye_y, eye_z, look_x, look_y, look_z,
		status, segment_index, points_held, output ready);
endinterface

`default_nettype wire

// ----- rtl/crp_ctrl.sv -----
`default_nettype none

module crp_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	input  wire crp_pkg::dp_stat_t stat,
	output crp_pkg::dp_ctrl_t    ctrl
);
	import crp_pkg::*;

	fsm_state_t state_q, state_nxt;
	logic [2:0] cnt_q;
	logic       out_vld_q;
	logic       can_load;

	assign can_load  = !out_vld_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_vld_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (req_valid) state_nxt = ST_EXEC;
			ST_EXEC:  state_nxt = (stat.cmd == CMD_ADVANCE) ? ST_WRAP : ST_DONE;
			ST_WRAP:  state_nxt = stat.few ? ST_DONE : ST_DIV;
			ST_DIV:   if (stat.div_done) state_nxt = ST_IDX;
			ST_IDX:   state_nxt = ST_T3;
			ST_T3:    state_nxt = ST_WGT;
			ST_WGT:   state_nxt = ST_MAC;
			ST_MAC:   if (cnt_q == MAC_LAST) state_nxt = ST_ROUND;
			ST_ROUND: state_nxt = ST_DONE;
			ST_DONE:  if (can_load) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.cnt = cnt_q;
		ctrl.op  = OP_NOP;
		unique case (state_q)
			ST_IDLE:  if (req_valid) ctrl.op = OP_LATCH;
			ST_EXEC:  ctrl.op = OP_EXEC;
			ST_WRAP:  ctrl.op = OP_WRAP;
			ST_DIV:   ctrl.op = OP_DIV;
			ST_IDX:   ctrl.op = OP_IDX;
			ST_T3:    ctrl.op = OP_T3;
			ST_WGT:   ctrl.op = OP_WGT;
			ST_MAC:   ctrl.op = OP_MAC;
			ST_ROUND: ctrl.op = OP_ROUND;
			ST_DONE:  if (can_load) ctrl.op = OP_LOAD;
			default:  ctrl.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= (state_q == ST_MAC) ? cnt_q + 3'd1 : 3'd0;
			if (state_q == ST_DONE && can_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/crp_datapath.sv -----
`default_nettype none

module crp_datapath #(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire crp_pkg::dp_ctrl_t     ctrl,
	output crp_pkg::dp_stat_t          stat,
	input  wire crp_pkg::req_payload_t req_data,
	output crp_pkg::rsp_payload_t      rsp_data
);
	import crp_pkg::*;

	localparam int NW   = $clog2(MAX_POINTS + 1);
	localparam int AW   = $clog2(MAX_POINTS);
	localparam int PW   = NW + FRAC_BITS;
	localparam int DCW  = $clog2(NW + 1);
	localparam int WW   = FRAC_BITS + 4;
	localparam int ACW  = WW + 34;
	localparam logic [NW-1:0]  MAX_N  = NW'(MAX_POINTS);
	localparam logic [DCW-1:0] DIV_N  = DCW'(NW);
	localparam logic signed [WW-1:0]  TWO   = WW'(2) <<< FRAC_BITS;
	localparam logic signed [ACW-1:0] HALF  = ACW'(1) <<< FRAC_BITS;
	localparam logic signed [ACW-1:0] SAT_HI = {{(ACW - 31){1'b0}}, {31{1'b1}}};
	localparam logic signed [ACW-1:0] SAT_LO = ~SAT_HI;

	// Latched item
	req_payload_t in_q;

	// Loop state
	logic [NW-1:0] total_q;
	logic [PW-1:0] pos_q;

	// Coordinate stores, one per lane
	logic [31:0] mem [NUM_LANES][MAX_POINTS];

	// Index reduction
	logic [NW-1:0]  quo_q;
	logic [NW-1:0]  rem_q;
	logic [DCW-1:0] div_cnt_q;
	logic [AW-1:0]  idx_q [4];

	// Weights
	logic [FRAC_BITS-1:0] t2_q, t3_q;
	logic signed [WW-1:0] w_q [4];

	// Lanes
	logic signed [31:0]     rd_s1   [NUM_LANES];
	logic signed [WW+31:0]  prod_s2 [NUM_LANES];
	logic signed [ACW-1:0]  acc_q   [NUM_LANES];
	logic [31:0]            coord_q [NUM_LANES];
	logic [1:0]             status_q;
	rsp_payload_t           out_q;

	logic                   full;
	logic [FRAC_BITS+17:0]  step_ext;
	logic [PW-1:0]          pos_add;
	logic [NW-1:0]          pos_int;
	logic [PW-1:0]          pos_wrap;
	logic [NW:0]            rem_sh;
	logic [NW-1:0]          rem_nxt;
	logic [NW-1:0]          i1, i2, i3, i0;
	logic [FRAC_BITS-1:0]   t;
	logic [2*FRAC_BITS-1:0] sq, cu;
	logic signed [WW-1:0]   tw, t2w, t3w;
	logic [1:0]             rd_sel, w_sel;

	assign full     = (total_q == MAX_N);
	assign step_ext = {in_q.time_delta, {FRAC_BITS{1'b0}}};
	assign pos_add  = pos_q + PW'(step_ext[FRAC_BITS+17:18]);
	assign pos_int  = pos_q[PW-1:FRAC_BITS];
	assign pos_wrap = (total_q != '0 && pos_int >= total_q)
		? pos_q - {total_q, {FRAC_BITS{1'b0}}} : pos_q;

	// Restoring remainder, one dividend bit per cycle
	assign rem_sh  = {rem_q, quo_q[NW-1]};
	assign rem_nxt = (rem_sh >= {1'b0, total_q}) ? NW'(rem_sh - {1'b0, total_q})
		: rem_sh[NW-1:0];

	assign i1 = rem_q;
	assign i2 = (i1 + NW'(1) == total_q) ? '0 : i1 + NW'(1);
	assign i3 = (i2 + NW'(1) == total_q) ? '0 : i2 + NW'(1);
	assign i0 = (i1 == '0) ? total_q - NW'(1) : i1 - NW'(1);

	assign t   = pos_q[FRAC_BITS-1:0];
	assign sq  = t * t;
	assign cu  = t2_q * t;
	assign tw  = signed'({4'b0, t});
	assign t2w = signed'({4'b0, t2_q});
	assign t3w = signed'({4'b0, t3_q});

	assign rd_sel = ctrl.cnt[1:0];
	assign w_sel  = 2'(ctrl.cnt - 3'd1);

	assign stat.cmd      = cmd_t'(in_q.command);
	assign stat.few      = (total_q < NW'(3));
	assign stat.div_done = (div_cnt_q == '0);
	assign rsp_data      = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			pos_q   <= '0;
		end else begin
			unique case (ctrl.op)
				OP_EXEC: begin
					unique case (cmd_t'(in_q.command))
						CMD_CLEAR:     total_q <= '0;
						CMD_APPEND:    if (!full) total_q <= total_q + NW'(1);
						CMD_RESET_POS: pos_q <= '0;
						CMD_ADVANCE:   if (total_q != '0) pos_q <= pos_add;
						default:       ;
					endcase
				end
				OP_WRAP: pos_q <= pos_wrap;
				default: ;
			endcase
		end
	end

	// Store write and registered lane read
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_EXEC && cmd_t'(in_q.command) == CMD_APPEND && !full) begin
			mem[0][total_q[AW-1:0]] <= in_q.eye_in_x;
			mem[1][total_q[AW-1:0]] <= in_q.eye_in_y;
			mem[2][total_q[AW-1:0]] <= in_q.eye_in_z;
			mem[3][total_q[AW-1:0]] <= in_q.look_in_x;
			mem[4][total_q[AW-1:0]] <= in_q.look_in_y;
			mem[5][total_q[AW-1:0]] <= in_q.look_in_z;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_LANES; l++) begin
			rd_s1[l] <= mem[l][idx_q[rd_sel]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (ctrl.op == OP_WRAP) begin
			div_cnt_q <= DIV_N;
		end else if (ctrl.op == OP_DIV && div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LATCH: in_q <= req_data;
			OP_EXEC: begin
				for (int l = 0; l < NUM_LANES; l++) coord_q[l] <= '0;
				status_q <= (cmd_t'(in_q.command) == CMD_APPEND && full)
					? STAT_FULL : STAT_OK;
			end
			OP_WRAP: begin
				quo_q <= pos_wrap[PW-1:FRAC_BITS];
				rem_q <= '0;
				if (stat.few) status_q <= STAT_SHORT;
			end
			OP_DIV: begin
				if (div_cnt_q != '0) begin
					rem_q <= rem_nxt;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end
			OP_IDX: begin
				idx_q[0] <= i0[AW-1:0];
				idx_q[1] <= i1[AW-1:0];
				idx_q[2] <= i2[AW-1:0];
				idx_q[3] <= i3[AW-1:0];
				t2_q     <= sq[2*FRAC_BITS-1:FRAC_BITS];
			end
			OP_T3: t3_q <= cu[2*FRAC_BITS-1:FRAC_BITS];
			OP_WGT: begin
				w_q[0] <= -t3w + (t2w <<< 1) - tw;
				w_q[1] <= (t3w <<< 1) + t3w - (t2w <<< 2) - t2w + TWO;
				w_q[2] <= -(t3w <<< 1) - t3w + (t2w <<< 2) + tw;
				w_q[3] <= t3w - t2w;
				for (int l = 0; l < NUM_LANES; l++) acc_q[l] <= '0;
			end
			OP_MAC: begin
				// Read issues at cnt 0..3, product at 1..4, accumulate at 2..5
				for (int l = 0; l < NUM_LANES; l++) begin
					if (ctrl.cnt >= 3'd1 && ctrl.cnt <= 3'd4) begin
						prod_s2[l] <= w_q[w_sel] * rd_s1[l];
					end
					if (ctrl.cnt >= 3'd2) begin
						acc_q[l] <= acc_q[l] + ACW'(prod_s2[l]);
					end
				end
			end
			OP_ROUND: begin
				for (int l = 0; l < NUM_LANES; l++) begin
					logic signed [ACW-1:0] sh;
					sh = (acc_q[l] + HALF) >>> (FRAC_BITS + 1);
					if (sh > SAT_HI) begin
						coord_q[l] <= SAT_HI[31:0];
					end else if (sh < SAT_LO) begin
						coord_q[l] <= SAT_LO[31:0];
					end else begin
						coord_q[l] <= sh[31:0];
					end
				end
			end
			OP_LOAD: begin
				out_q.eye_x         <= coord_q[0];
				out_q.eye_y         <= coord_q[1];
				out_q.eye_z         <= coord_q[2];
				out_q.look_x        <= coord_q[3];
				out_q.look_y        <= coord_q[4];
				out_q.look_z        <= coord_q[5];
				out_q.status        <= status_q;
				out_q.segment_index <= 6'(pos_int);
				out_q.points_held   <= 7'(total_q);
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/catmull_rom_loop_path_follower.sv -----
// Closed-loop Catmull-Rom camera path follower.
// req channel (valid/ready): one command item: clear the loop, append an
// eye/look-at point, reset the path position, or advance by time_delta.
// rsp channel (valid/ready): exactly one result item per request item, in
// order: interpolated eye and look-at (Q16.16, saturated), status, segment
// index and point count.
// Clear, append and position reset pass from acceptance through the
// execute and done states to the output register. Advance also wraps the
// position; a short loop (fewer than three points) then goes to done, else
// a bit-serial index remainder over NW = clog2(MAX_POINTS+1) bits (one bit a
// cycle), the weights and a four-point multiply-accumulate that reads one
// stored point per cycle in six coordinate lanes come before the rounding.
// One item is worked at a time; the next is taken as soon as the previous
// result sits in the output register, even if the receiver has not taken it.
// While rsp.ready stays low the result holds, and a finished second item
// waits inside until the output register frees.
// Reset empties the loop and zeroes the position; the point store is not
// cleared and needs no sweep.
`default_nettype none

module catmull_rom_loop_path_follower #(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	crp_req_if.sink   req,
	crp_rsp_if.source rsp
);
	import crp_pkg::*;

	dp_ctrl_t     ctrl;
	dp_stat_t     stat;
	req_payload_t req_data;
	rsp_payload_t rsp_data;

	// Pack the request fields for the datapath
	assign req_data.command    = req.command;
	assign req_data.eye_in_x   = req.eye_in_x;
	assign req_data.eye_in_y   = req.eye_in_y;
	assign req_data.eye_in_z   = req.eye_in_z;
	assign req_data.look_in_x  = req.look_in_x;
	assign req_data.look_in_y  = req.look_in_y;
	assign req_data.look_in_z  = req.look_in_z;
	assign req_data.time_delta = req.time_delta;

	// Drive the result fields straight from the output register
	assign rsp.eye_x         = rsp_data.eye_x;
	assign rsp.eye_y         = rsp_data.eye_y;
	assign rsp.eye_z         = rsp_data.eye_z;
	assign rsp.look_x        = rsp_data.look_x;
	assign rsp.look_y        = rsp_data.look_y;
	assign rsp.look_z        = rsp_data.look_z;
	assign rsp.status        = rsp_data.status;
	assign rsp.segment_index = rsp_data.segment_index;
	assign rsp.points_held   = rsp_data.points_held;

	crp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	crp_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.stat     (stat),
		.req_data (req_data),
		.rsp_data (rsp_data)
	);

endmodule

`default_nettype wire

// ----- tb/sv/crp_tb_ifs.sv -----
`timescale 1ns / 100ps

// Item records held by the scoreboard.
package crp_tb_pkg;
	import crp_pkg::*;

	typedef struct {
		cmd_t            command;
		logic [31:0]     eye[3];
		logic [31:0]     look[3];
		logic [17:0]     time_delta;
	} path_cmd_t;

	typedef struct {
		logic [31:0] eye[3];
		logic [31:0] look[3];
		logic [1:0]  status;
		logic [5:0]  segment_index;
		logic [6:0]  points_held;
	} path_pose_t;
endpackage

// ----- tb/sv/catmull_rom_loop_path_follower_tb.sv -----
`timescale 1ns / 100ps

import crp_pkg::*;
import crp_tb_pkg::*;

// Scoreboard: its own copy of the loop store, the point count and the path
// position, and the queue of poses waiting for the block to produce them.
class path_scoreboard;
	localparam int NPTS = 64;
	localparam int FB   = 16;

	longint     eye_store[3*NPTS];
	longint     look_store[3*NPTS];
	int         point_count;
	longint     position;
	path_pose_t pending_poses[$];
	int         errors;

	function new();
		point_count = 0;
		position = 0;
		errors = 0;
	endfunction

	// Blend one coordinate over the four neighbors, round half up, saturate.
	function logic [31:0] blend(ref longint store[3*NPTS], input int axis,
			input int idx[4], input longint w[4]);
		longint acc;
		longint q;
		acc = 0;
		for (int k = 0; k < 4; k++)
			acc += w[k] * store[idx[k]*3 + axis];
		acc += longint'(1) << FB;
		q = acc >>> (FB + 1);
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[31:0];
	endfunction

	// Apply one accepted command and queue the pose it must produce.
	function void note_command(path_cmd_t c);
		path_pose_t p;
		longint t, t2, t3, w[4];
		int n, i, idx[4];
		for (int a = 0; a < 3; a++) begin
			p.eye[a] = '0;
			p.look[a] = '0;
		end
		p.status = STAT_OK;
		case (c.command)
			CMD_CLEAR: begin
				point_count = 0;
			end
			CMD_APPEND: begin
				if (point_count >= NPTS) begin
					p.status = STAT_FULL;
				end else begin
					for (int a = 0; a < 3; a++) begin
						eye_store[point_count*3 + a] = longint'(signed'(c.eye[a]));
						look_store[point_count*3 + a] = longint'(signed'(c.look[a]));
					end
					point_count++;
				end
			end
			CMD_RESET_POS: begin
				position = 0;
			end
			default: begin
				n = point_count;
				if (n > 0) begin
					position += (longint'(c.time_delta) << FB) >> 18;
					if ((position >> FB) > n - 1)
						position -= longint'(n) << FB;
				end
				if (n < 3) begin
					p.status = STAT_SHORT;
				end else begin
					i = int'(position >> FB);
					t = position & ((longint'(1) << FB) - 1);
					t2 = (t * t) >> FB;
					t3 = (t2 * t) >> FB;
					w[0] = -t3 + 2*t2 - t;
					w[1] = 3*t3 - 5*t2 + (longint'(2) << FB);
					w[2] = -3*t3 + 4*t2 + t;
					w[3] = t3 - t2;
					idx[0] = (i + n - 1) % n;
					idx[1] = i % n;
					idx[2] = (i + 1) % n;
					idx[3] = (i + 2) % n;
					for (int a = 0; a < 3; a++) begin
						p.eye[a] = blend(eye_store, a, idx, w);
						p.look[a] = blend(look_store, a, idx, w);
					end
				end
			end
		endcase
		p.segment_index = 6'(position >> FB);
		p.points_held = 7'(point_count);
		pending_poses.insert(pending_poses.size(), p);
	endfunction

	function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
		$display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
		errors++;
	endfunction

	// Compare one produced pose with the oldest expected one.
	function void check_pose(path_pose_t r);
		path_pose_t e;
		if (pending_poses.size() == 0) begin
			$display("%0t: unexpected result item, status %0d", $time, r.status);
			errors++;
			return;
		end
		e = pending_poses.pop_front();
		for (int a = 0; a < 3; a++) begin
			if (r.eye[a] !== e.eye[a])
				report($sformatf("eye[%0d]", a), e.eye[a], r.eye[a]);
			if (r.look[a] !== e.look[a])
				report($sformatf("look[%0d]", a), e.look[a], r.look[a]);
		end
		if (r.status !== e.status)
			report("status", 32'(e.status), 32'(r.status));
		if (r.segment_index !== e.segment_index)
			report("segment_index", 32'(e.segment_index), 32'(r.segment_index));
		if (r.points_held !== e.points_held)
			report("points_held", 32'(e.points_held), 32'(r.points_held));
	endfunction
endclass

module catmull_rom_loop_path_follower_tb;
	localparam int WATCHDOG_CYCLES = 20000;

	logic clk;
	logic arst_n;

	crp_req_if req();
	crp_rsp_if rsp();

	catmull_rom_loop_path_follower #(
		.MAX_POINTS(64),
		.FRAC_BITS (16)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	path_scoreboard sb;
	int  idle_cycles;
	bit  stim_done;
	// Set while the result side must hold off for a long stretch.
	bit  hold_request;
	bit  holding;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Any 32-bit coordinate, biased toward the extremes and small values.
	function automatic logic [31:0] coord_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($urandom_range(0, 2000000)) - 32'd1000000;
			default: return $urandom;
		endcase
	endfunction

	function automatic path_cmd_t make_cmd(cmd_t c, logic [17:0] td);
		path_cmd_t m;
		m.command = c;
		for (int a = 0; a < 3; a++) begin
			m.eye[a] = coord_value();
			m.look[a] = coord_value();
		end
		m.time_delta = td;
		return m;
	endfunction

	// Offer one item at the falling edge and hold it until accepted.
	task automatic send_cmd(path_cmd_t m);
		int g;
		g = gap_length();
		repeat (g) begin
			@(negedge clk);
			req.valid <= 1'b0;
		end
		@(negedge clk);
		req.valid      <= 1'b1;
		req.command    <= m.command;
		req.eye_in_x   <= m.eye[0];
		req.eye_in_y   <= m.eye[1];
		req.eye_in_z   <= m.eye[2];
		req.look_in_x  <= m.look[0];
		req.look_in_y  <= m.look[1];
		req.look_in_z  <= m.look[2];
		req.time_delta <= m.time_delta;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_command(m);
	endtask

	// Pause until every expected result has come back.
	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (sb.pending_poses.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			send_cmd(make_cmd(CMD_CLEAR, '0));
		else if (r < 6)
			send_cmd(make_cmd(CMD_RESET_POS, 18'($urandom)));
		else if (r < 40)
			send_cmd(make_cmd(CMD_APPEND, 18'($urandom)));
		else if (r < 90)
			send_cmd(make_cmd(CMD_ADVANCE, 18'($urandom_range(0, 262143))));
		else
			send_cmd(make_cmd(CMD_ADVANCE, $urandom_range(0, 3) == 0 ? 18'h3ffff :
				18'($urandom_range(0, 8191))));
	endtask

	// Stimulus: directed corners, then random traffic in phases.
	initial begin
		sb = new();
		arst_n = 1'b0;
		stim_done = 1'b0;
		hold_request = 1'b0;
		req.valid = 1'b0;
		req.command = CMD_CLEAR;
		req.eye_in_x = '0;
		req.eye_in_y = '0;
		req.eye_in_z = '0;
		req.look_in_x = '0;
		req.look_in_y = '0;
		req.look_in_z = '0;
		req.time_delta = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Advance on an empty loop keeps position zero; then a short loop.
		send_cmd(make_cmd(CMD_ADVANCE, 18'h3ffff));
		send_cmd(make_cmd(CMD_APPEND, '0));
		send_cmd(make_cmd(CMD_ADVANCE, 18'h3ffff));
		send_cmd(make_cmd(CMD_APPEND, '0));
		send_cmd(make_cmd(CMD_ADVANCE, 18'h20000));
		send_cmd(make_cmd(CMD_APPEND, '0));
		// Three points: zero step, full range step, wrap.
		send_cmd(make_cmd(CMD_ADVANCE, 18'h0));
		send_cmd(make_cmd(CMD_ADVANCE, 18'h3ffff));
		send_cmd(make_cmd(CMD_ADVANCE, 18'h3ffff));
		send_cmd(make_cmd(CMD_ADVANCE, 18'h3ffff));
		send_cmd(make_cmd(CMD_RESET_POS, '0));
		send_cmd(make_cmd(CMD_ADVANCE, 18'h00001));
		// Grow the loop, then clear so the position sits beyond a small loop.
		repeat (6) send_cmd(make_cmd(CMD_APPEND, '0));
		repeat (8) send_cmd(make_cmd(CMD_ADVANCE, 18'h3ffff));
		send_cmd(make_cmd(CMD_CLEAR, '0));
		repeat (3) send_cmd(make_cmd(CMD_APPEND, '0));
		send_cmd(make_cmd(CMD_ADVANCE, 18'h10000));
		drain();

		// Fill past capacity so appends drop, and walk the full loop.
		repeat (66) send_cmd(make_cmd(CMD_APPEND, '0));
		repeat (120) send_cmd(make_cmd(CMD_ADVANCE, 18'($urandom_range(0, 262143))));

		// Hold off the result side while requests keep coming.
		hold_request = 1'b1;
		repeat (20) send_cmd(make_cmd(CMD_ADVANCE, 18'($urandom_range(0, 262143))));
		hold_request = 1'b0;
		drain();

		send_cmd(make_cmd(CMD_CLEAR, '0));
		repeat (850) send_random_cmd();
		drain();
		stim_done = 1'b1;
	end

	// Result side: random stalls, and one long stretch on request.
	initial begin
		int g;
		holding = 1'b0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !holding) begin
				holding = 1'b1;
				rsp.ready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			g = gap_length();
			if (g > 0) begin
				rsp.ready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Sample results at the rising edge.
	always @(posedge clk) begin
		path_pose_t r;
		if (arst_n && rsp.valid && rsp.ready) begin
			r.eye[0] = rsp.eye_x;
			r.eye[1] = rsp.eye_y;
			r.eye[2] = rsp.eye_z;
			r.look[0] = rsp.look_x;
			r.look[1] = rsp.look_y;
			r.look[2] = rsp.look_z;
			r.status = rsp.status;
			r.segment_index = rsp.segment_index;
			r.points_held = rsp.points_held;
			sb.check_pose(r);
		end
	end

	// Watchdog over quiet cycles, and the final verdict.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (stim_done) begin
				repeat (40) @(posedge clk);
				if (sb.errors == 0 && sb.pending_poses.size() == 0)
					$display("catmull_rom_loop_path_follower_tb OK");
				else
					$display("catmull_rom_loop_path_follower_tb NOT OK");
				$finish;
			end else if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("%0t: timeout", $time);
				$display("catmull_rom_loop_path_follower_tb NOT OK");
				$finish;
			end
		end
	end
endmodule

// ----- files.f -----
rtl/crp_pkg.sv
rtl/crp_ifs.sv
rtl/crp_ctrl.sv
rtl/crp_datapath.sv
rtl/catmull_rom_loop_path_follower.sv
tb/sv/crp_tb_ifs.sv
tb/sv/catmull_rom_loop_path_follower_tb.sv
